// ----- rtl/can_frag_pkg.sv -----
`default_nettype none
package can_frag_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_SENDER_ID      = 3'd0;
	localparam logic [2:0] REG_SHORT_CODE     = 3'd1;
	localparam logic [2:0] REG_FILL_CODE      = 3'd2;
	localparam logic [2:0] REG_FILL_LONG_CODE = 3'd3;
	localparam logic [2:0] REG_PROCESS_CODE   = 3'd4;
	localparam logic [2:0] REG_CRC_POLY       = 3'd5;

	localparam logic [7:0]  ID_OFFSET   = 8'd128;
	localparam logic [15:0] FILL_LIMIT  = 16'd259;
	localparam logic [2:0]  FILL_SIZE   = 3'd7;
	localparam logic [2:0]  LONG_SIZE   = 3'd6;
	localparam logic [15:0] SHORT_MAX   = 16'd6;
	localparam logic [3:0]  CLOSE_LEN   = 4'd6;

	typedef struct packed {
		logic [6:0]  sender_id;
		logic [7:0]  short_code;
		logic [7:0]  fill_code;
		logic [7:0]  fill_long_code;
		logic [7:0]  process_code;
		logic [15:0] crc_poly;
	} cfg_t;

	typedef struct packed {
		logic [28:0] frame_id;
		logic [3:0]  frame_len;
		logic [63:0] frame_data;
		logic        last_frame;
		logic        overflow;
	} frame_t;

	// results of one item handed to the output queue
	typedef struct packed {
		logic       push;
		logic [1:0] count;
		frame_t     r0;
		frame_t     r1;
	} push_t;

	// MSB-first CRC-16, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
			input logic [15:0] poly);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/can_frag_step.sv -----
`default_nettype none
module can_frag_step import can_frag_pkg::*; #(
	parameter int MAX_LEN = 512
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        commit,
	input  wire [7:0]  data_byte,
	input  wire        last_byte,
	input  wire [7:0]  dest_id,
	input  wire        send_flag,
	input  wire cfg_t  cfg,
	output push_t      res
);

	logic [55:0] pend_q;
	logic [2:0]  pcnt_q;
	logic [15:0] total_q;
	logic [15:0] crc_q;
	logic [7:0]  dest_q;
	logic        send_q;
	logic        err_q;

	logic [55:0] pend_n;
	logic [2:0]  pcnt_n;
	logic [15:0] total_n;
	logic [15:0] crc_n;
	logic [7:0]  dest_n;
	logic        send_n;
	logic        err_n;

	logic [15:0] start;
	logic        long_mode;
	logic        chunk;
	logic [7:0]  lead;
	frame_t      chunk_f;
	frame_t      final_f;
	frame_t      ovf_f;
	logic [63:0] short_data;
	logic [63:0] long_data;

	always_comb begin
		err_n   = err_q || (total_q >= 16'(MAX_LEN));
		dest_n  = (total_q == 16'd0) ? dest_id : dest_q;
		send_n  = (total_q == 16'd0) ? send_flag : send_q;
		crc_n   = crc_byte(crc_q, data_byte, cfg.crc_poly);
		pcnt_n  = pcnt_q + 3'd1;
		total_n = total_q + 16'd1;
		pend_n  = pend_q;
		for (int k = 0; k < 7; k++) begin
			if (pcnt_q == 3'(k)) begin
				pend_n[8*k +: 8] = data_byte;
			end
		end

		start     = total_q - {13'd0, pcnt_q};
		long_mode = !(start < FILL_LIMIT);
		chunk     = (long_mode ? (pcnt_n >= LONG_SIZE) : (pcnt_n >= FILL_SIZE))
			|| (last_byte && (total_n > SHORT_MAX));
		lead      = {1'b0, cfg.sender_id} + ID_OFFSET;

		long_data = {pend_n[47:0], start[7:0], start[15:8]};
		chunk_f.last_frame = 1'b0;
		chunk_f.overflow   = 1'b0;
		if (long_mode) begin
			chunk_f.frame_id   = {13'd0, cfg.fill_long_code, dest_n};
			chunk_f.frame_len  = {1'b0, pcnt_n} + 4'd2;
			chunk_f.frame_data = long_data;
		end else begin
			chunk_f.frame_id   = {13'd0, cfg.fill_code, dest_n};
			chunk_f.frame_len  = {1'b0, pcnt_n} + 4'd1;
			chunk_f.frame_data = {pend_n, start[7:0]};
		end

		short_data = {pend_n[47:0], 7'd0, send_n, lead};
		final_f.last_frame = 1'b1;
		final_f.overflow   = 1'b0;
		if (total_n > SHORT_MAX) begin
			final_f.frame_id   = {13'd0, cfg.process_code, dest_n};
			final_f.frame_len  = CLOSE_LEN;
			final_f.frame_data = {16'd0, crc_n[7:0], crc_n[15:8], total_n[7:0],
				total_n[15:8], 7'd0, send_n, lead};
		end else begin
			final_f.frame_id   = {13'd0, cfg.short_code, dest_n};
			final_f.frame_len  = {1'b0, pcnt_n} + 4'd2;
			final_f.frame_data = short_data;
		end

		ovf_f.frame_id   = '0;
		ovf_f.frame_len  = '0;
		ovf_f.frame_data = '0;
		ovf_f.last_frame = 1'b1;
		ovf_f.overflow   = 1'b1;

		res.push = commit;
		res.r1   = final_f;
		if (err_n) begin
			res.count = {1'b0, last_byte};
			res.r0    = ovf_f;
		end else if (chunk) begin
			res.count = last_byte ? 2'd2 : 2'd1;
			res.r0    = chunk_f;
		end else begin
			res.count = {1'b0, last_byte};
			res.r0    = final_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			pcnt_q  <= '0;
			total_q <= '0;
			crc_q   <= '0;
			dest_q  <= '0;
			send_q  <= 1'b0;
			err_q   <= 1'b0;
		end else if (commit) begin
			if (last_byte) begin
				// packet done: back to a clean slate
				pend_q  <= '0;
				pcnt_q  <= '0;
				total_q <= '0;
				crc_q   <= '0;
				dest_q  <= '0;
				send_q  <= 1'b0;
				err_q   <= 1'b0;
			end else if (err_n) begin
				err_q <= 1'b1;
			end else begin
				pend_q  <= chunk ? 56'd0 : pend_n;
				pcnt_q  <= chunk ? 3'd0 : pcnt_n;
				total_q <= total_n;
				crc_q   <= crc_n;
				dest_q  <= dest_n;
				send_q  <= send_n;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/can_frag_outq.sv -----
`default_nettype none
module can_frag_outq import can_frag_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire push_t res,
	input  wire        pop,
	output logic       free,
	output logic       valid,
	output frame_t     head
);

	frame_t     slot0_q;
	frame_t     slot1_q;
	logic [1:0] cnt_q;

	assign free  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
	assign valid = (cnt_q != 2'd0);
	assign head  = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (res.push) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (res.push) begin
			slot0_q <= res.r0;
			slot1_q <= res.r1;
		end else if (pop) begin
			// advance the second frame to the head
			slot0_q <= slot1_q;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/can_packet_fragmenter.sv -----
// CAN packet fragmenter.
// Slave stream: one payload byte per item. s_tdata = data_byte [7:0], dest_id [15:8];
// s_tlast marks the last byte of a packet; s_tuser carries send_flag. dest_id and
// send_flag are sampled on the first byte of a packet only.
// Master stream: one CAN frame per item. m_tdata = frame_id [28:0], frame_len [32:29],
// frame_data [96:33], zero [103:97]; m_tlast marks the last frame of a packet and
// m_tuser flags an overflowed packet (dropped, frame fields zero).
// Registers must be written through cfg_we/cfg_addr/cfg_wdata only while the block is
// idle; the block itself does not enforce this. A frame reaches the master side through
// the input register and then the two-entry frame buffer.
// Throughput: one byte per cycle while each byte yields at most one frame and the
// receiver takes every frame; a byte that completes both a fill frame and the closing
// frame holds the input until the single output port has drained the frame buffer.
// Reset clears the packet state, empties both stages and loads the default registers.
// When the receiver stalls, the held frames stay put and the input stage fills and
// then drops s_tready; nothing is lost.
`default_nettype none
module can_packet_fragmenter import can_frag_pkg::*; #(
	parameter int MAX_LEN = 512
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [15:0]  s_tdata,   // data_byte, dest_id
	input  wire          s_tlast,
	input  wire          s_tuser,   // send_flag
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [103:0] m_tdata,   // frame_id, frame_len, frame_data, zero pad
	output logic         m_tlast,
	output logic         m_tuser,   // overflow
	input  wire          cfg_we,
	input  wire  [2:0]   cfg_addr,
	input  wire  [15:0]  cfg_wdata
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic [7:0] dest_s1;
	logic       last_s1;
	logic       send_s1;
	logic       commit;
	logic       free;
	logic       pop;
	push_t      res;
	frame_t     head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sender_id      <= 7'd0;
			cfg_q.short_code     <= 8'd8;
			cfg_q.fill_code      <= 8'd5;
			cfg_q.fill_long_code <= 8'd6;
			cfg_q.process_code   <= 8'd7;
			cfg_q.crc_poly       <= 16'h1021;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SENDER_ID:      cfg_q.sender_id      <= cfg_wdata[6:0];
				REG_SHORT_CODE:     cfg_q.short_code     <= cfg_wdata[7:0];
				REG_FILL_CODE:      cfg_q.fill_code      <= cfg_wdata[7:0];
				REG_FILL_LONG_CODE: cfg_q.fill_long_code <= cfg_wdata[7:0];
				REG_PROCESS_CODE:   cfg_q.process_code   <= cfg_wdata[7:0];
				REG_CRC_POLY:       cfg_q.crc_poly       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign commit   = valid_s1 && free;
	assign s_tready = !valid_s1 || commit;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata[7:0];
			dest_s1 <= s_tdata[15:8];
			last_s1 <= s_tlast;
			send_s1 <= s_tuser;
		end
	end

	can_frag_step #(
		.MAX_LEN(MAX_LEN)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.dest_id   (dest_s1),
		.send_flag (send_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	can_frag_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.pop    (pop),
		.free   (free),
		.valid  (m_tvalid),
		.head   (head)
	);

	assign m_tdata = {7'd0, head.frame_data, head.frame_len, head.frame_id};
	assign m_tlast = head.last_frame;
	assign m_tuser = head.overflow;

endmodule
`default_nettype wire

// ----- bench/tb_can_packet_fragmenter.sv -----
`timescale 1ns / 100ps
module tb_can_packet_fragmenter;
	import can_frag_pkg::*;

	localparam int PKT_MAX = 512;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic [7:0] dest;
		logic       send;
	} byte_item_t;

	typedef enum {PAT_RANDOM, PAT_ZERO, PAT_ONES} pattern_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [15:0]   s_tdata;     // data_byte, dest_id
	logic          s_tlast;     // last_byte
	logic          s_tuser;     // send_flag
	logic          m_tvalid;
	logic          m_tready;
	logic [103:0]  m_tdata;     // frame_id, frame_len, frame_data, zero pad
	logic          m_tlast;     // last_frame
	logic          m_tuser;     // overflow
	logic          cfg_we;
	logic [2:0]    cfg_addr;
	logic [15:0]   cfg_wdata;

	can_packet_fragmenter #(.MAX_LEN(PKT_MAX)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	byte_item_t byte_q[$];
	byte_item_t cur_byte;
	frame_t     frame_q[$];
	int         bytes_queued;
	int         bytes_taken;
	int         errors;
	int         cyc;
	bit         took;
	bit         quiet;

	// shadow of the registers and the packet in progress
	cfg_t        regs;
	logic [55:0] pkt_bytes;
	int          pkt_cnt;
	int          pkt_total;
	logic [15:0] pkt_crc;
	logic [7:0]  pkt_dest;
	logic        pkt_send;
	bit          pkt_err;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] crc_next(logic [15:0] c_in, logic [7:0] b,
			logic [15:0] poly);
		logic [15:0] c;
		c = c_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic frame_t frame_of(logic [7:0] code, logic [3:0] len, logic [63:0] data,
			logic last, logic ovf);
		frame_t f;
		f.frame_id = {13'd0, code, pkt_dest};
		f.frame_len = len;
		f.frame_data = data;
		f.last_frame = last;
		f.overflow = ovf;
		return f;
	endfunction

	task automatic clear_packet();
		pkt_bytes = '0;
		pkt_cnt = 0;
		pkt_total = 0;
		pkt_crc = '0;
		pkt_dest = '0;
		pkt_send = 1'b0;
		pkt_err = 1'b0;
	endtask

	// offsets below the limit travel as one byte, later ones as two (high first)
	task automatic push_chunk(int start);
		if (start < int'(FILL_LIMIT)) begin
			frame_q.push_back(frame_of(regs.fill_code, 4'(pkt_cnt + 1),
				{pkt_bytes, 8'(start)}, 1'b0, 1'b0));
		end else begin
			frame_q.push_back(frame_of(regs.fill_long_code, 4'(pkt_cnt + 2),
				{pkt_bytes[47:0], 8'(start), 8'(start >> 8)}, 1'b0, 1'b0));
		end
		pkt_bytes = '0;
		pkt_cnt = 0;
	endtask

	task automatic predict_frames(byte_item_t it);
		int start;
		int size;
		logic [7:0] lead;
		lead = 8'(regs.sender_id) + ID_OFFSET;
		if (!pkt_err && pkt_total >= PKT_MAX) pkt_err = 1'b1;
		if (pkt_err) begin
			// drop the byte; the last one reports the overflow
			if (it.last) begin
				pkt_dest = '0;
				frame_q.push_back(frame_of(8'd0, 4'd0, 64'd0, 1'b1, 1'b1));
				clear_packet();
			end
		end else begin
			if (pkt_total == 0) begin
				pkt_dest = it.dest;
				pkt_send = it.send;
			end
			pkt_crc = crc_next(pkt_crc, it.data, regs.crc_poly);
			pkt_bytes[8*pkt_cnt +: 8] = it.data;
			pkt_cnt++;
			pkt_total++;
			start = pkt_total - pkt_cnt;
			size = (start < int'(FILL_LIMIT)) ? int'(FILL_SIZE) : int'(LONG_SIZE);
			if (pkt_cnt >= size) push_chunk(start);
			if (it.last) begin
				if (pkt_total <= int'(SHORT_MAX)) begin
					frame_q.push_back(frame_of(regs.short_code, 4'(pkt_cnt + 2),
						{pkt_bytes[47:0], 7'd0, pkt_send, lead}, 1'b1, 1'b0));
				end else begin
					if (pkt_cnt > 0) push_chunk(pkt_total - pkt_cnt);
					frame_q.push_back(frame_of(regs.process_code, CLOSE_LEN,
						{16'd0, pkt_crc[7:0], pkt_crc[15:8], 8'(pkt_total),
						8'(pkt_total >> 8), 7'd0, pkt_send, lead}, 1'b1, 1'b0));
				end
				clear_packet();
			end
		end
	endtask

	task automatic add_packet(int len, pattern_t pat);
		byte_item_t it;
		for (int i = 0; i < len; i++) begin
			case (pat)
				PAT_ZERO: begin
					it.data = 8'h00; it.dest = 8'h00; it.send = 1'b0;
				end
				PAT_ONES: begin
					it.data = 8'hFF; it.dest = 8'hFF; it.send = 1'b1;
				end
				default: begin
					it.data = 8'($urandom);
					it.dest = 8'($urandom);
					it.send = 1'($urandom);
				end
			endcase
			it.last = (i == len - 1);
			byte_q.push_back(it);
			bytes_queued++;
		end
	endtask

	// mostly short and medium packets, a few that cross into long offsets or overflow
	task automatic add_random_packets(int budget);
		int n;
		int len;
		int r;
		n = 0;
		while (n < budget) begin
			r = $urandom_range(0, 99);
			if (r < 50) len = $urandom_range(1, 6);
			else if (r < 90) len = $urandom_range(7, 40);
			else if (r < 97) len = $urandom_range(250, 300);
			else len = $urandom_range(505, 520);
			add_packet(len, PAT_RANDOM);
			n += len;
		end
	endtask

	task automatic wait_idle();
		while (bytes_taken != bytes_queued || frame_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		case (addr)
			REG_SENDER_ID:      regs.sender_id = val[6:0];
			REG_SHORT_CODE:     regs.short_code = val[7:0];
			REG_FILL_CODE:      regs.fill_code = val[7:0];
			REG_FILL_LONG_CODE: regs.fill_long_code = val[7:0];
			REG_PROCESS_CODE:   regs.process_code = val[7:0];
			REG_CRC_POLY:       regs.crc_poly = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [15:0] sid, logic [15:0] sc, logic [15:0] fc,
			logic [15:0] flc, logic [15:0] pc, logic [15:0] poly);
		write_reg(REG_SENDER_ID, sid);
		write_reg(REG_SHORT_CODE, sc);
		write_reg(REG_FILL_CODE, fc);
		write_reg(REG_FILL_LONG_CODE, flc);
		write_reg(REG_PROCESS_CODE, pc);
		write_reg(REG_CRC_POLY, poly);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_random_regs();
		set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	// driver: advance on acceptance, otherwise hold
	always @(negedge clk) begin
		if (!s_tvalid || took) begin
			if (byte_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 17)) begin
				cur_byte = byte_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {cur_byte.dest, cur_byte.data};
				s_tlast <= cur_byte.last;
				s_tuser <= cur_byte.send;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= quiet || ($urandom_range(0, 99) >= 17);
	end

	// monitor: predict on each accepted item, check each accepted frame
	always @(posedge clk) begin
		frame_t got;
		frame_t want;
		cyc++;
		quiet = (cyc >= 1000 && cyc < 1600);
		took = s_tvalid && s_tready;
		if (took) begin
			predict_frames(cur_byte);
			bytes_taken++;
		end
		if (m_tvalid && m_tready) begin
			got.frame_id = m_tdata[28:0];
			got.frame_len = m_tdata[32:29];
			got.frame_data = m_tdata[96:33];
			got.last_frame = m_tlast;
			got.overflow = m_tuser;
			if (frame_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected frame at cycle %0d: id %h len %0d data %h",
						cyc, got.frame_id, got.frame_len, got.frame_data);
			end else begin
				want = frame_q.pop_front();
				if (got.frame_id !== want.frame_id || got.frame_len !== want.frame_len ||
						got.frame_data !== want.frame_data ||
						got.last_frame !== want.last_frame ||
						got.overflow !== want.overflow) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch at cycle %0d", cyc);
						$display("  expected id %h len %0d data %h last %b ovf %b",
							want.frame_id, want.frame_len, want.frame_data,
							want.last_frame, want.overflow);
						$display("  got      id %h len %0d data %h last %b ovf %b",
							got.frame_id, got.frame_len, got.frame_data,
							got.last_frame, got.overflow);
					end
				end
			end
		end
		if (cyc >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		took = 1'b0;
		quiet = 1'b0;
		cyc = 0;
		errors = 0;
		bytes_queued = 0;
		bytes_taken = 0;
		regs.sender_id = 7'd0;
		regs.short_code = 8'd8;
		regs.fill_code = 8'd5;
		regs.fill_long_code = 8'd6;
		regs.process_code = 8'd7;
		regs.crc_poly = 16'h1021;
		clear_packet();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset values: single byte, full short frame, exact fill, fill plus remainder
		add_packet(1, PAT_ONES);
		add_packet(6, PAT_ZERO);
		add_packet(7, PAT_RANDOM);
		add_packet(8, PAT_ONES);
		wait_idle();

		set_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_packet(264, PAT_RANDOM);
		add_random_packets(80);
		wait_idle();

		set_regs(16'h007F, 16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 16'hFFFF);
		add_packet(PKT_MAX, PAT_RANDOM);
		add_random_packets(80);
		wait_idle();

		write_reg(REG_UNUSED, 16'($urandom));
		set_random_regs();
		add_packet(PKT_MAX + 1, PAT_RANDOM);
		add_random_packets(80);
		wait_idle();

		set_random_regs();
		add_random_packets(80);
		wait_idle();

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
